### rtl/ptc_pkg.sv
// ----------------------------------------------------------------------------
// ptc_pkg
// types and constants shared by the compensation pipeline
// ----------------------------------------------------------------------------
package ptc_pkg;

	// one raw sensor sample pair
	typedef struct packed {
		logic [19:0] raw_temperature;
		logic [19:0] raw_pressure;
	} in_t;

	// one compensated result
	typedef struct packed {
		logic signed [19:0] temperature_centi;
		logic [31:0]        pressure_fixed;
	} out_t;

	// configuration register indexes
	localparam logic [1:0] REG_TEMP_TRIM       = 2'd0;
	localparam logic [1:0] REG_PRESS_TRIM_LOW  = 2'd1;
	localparam logic [1:0] REG_PRESS_TRIM_HIGH = 2'd2;
	localparam logic [1:0] REG_PRESS_TRIM_LAST = 2'd3;

	localparam int DIV_W  = 64;
	localparam int SIDE_W = 22;

	localparam logic [63:0]        PRESS_SCALE = 64'd3125;
	localparam logic signed [31:0] TFINE_BASE  = 32'sd128000;
	localparam logic [20:0]        RAW_FULL    = 21'd1048576;
	localparam logic [63:0]        P1_OFFSET   = 64'h0000_8000_0000_0000;

endpackage

### rtl/pressure_temperature_compensation_unit.sv
// ----------------------------------------------------------------------------
// pressure_temperature_compensation_unit
// integer temperature and pressure compensation of raw sensor samples
// throughput: one transaction per cycle, busy is always low
// depth is set by the 64-stage pipelined divider, one quotient bit per stage
// reset: trim registers clear to zero and all stage valid bits clear
// the receiver cannot stall, a result is on the ports for one cycle only
// ----------------------------------------------------------------------------
module pressure_temperature_compensation_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ptc_pkg::in_t  sample,
	output logic          done,
	output ptc_pkg::out_t result,
	input  logic          cfg_we,
	input  logic [1:0]    cfg_index,
	input  logic [63:0]   cfg_data
);
	import ptc_pkg::*;

	// trim registers
	logic [47:0] temp_trim_q;
	logic [63:0] press_lo_q;
	logic [63:0] press_hi_q;
	logic [15:0] press_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			temp_trim_q  <= '0;
			press_lo_q   <= '0;
			press_hi_q   <= '0;
			press_last_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_TEMP_TRIM:       temp_trim_q  <= cfg_data[47:0];
				REG_PRESS_TRIM_LOW:  press_lo_q   <= cfg_data;
				REG_PRESS_TRIM_HIGH: press_hi_q   <= cfg_data;
				REG_PRESS_TRIM_LAST: press_last_q <= cfg_data[15:0];
				default: ;
			endcase
		end
	end

	// trim word split, T1 and P1 unsigned, the rest signed
	logic [15:0]        t1, p1;
	logic signed [15:0] t2, t3, p2, p3, p4, p5, p6, p7, p8, p9;
	assign t1 = temp_trim_q[15:0];
	assign t2 = temp_trim_q[31:16];
	assign t3 = temp_trim_q[47:32];
	assign p1 = press_lo_q[15:0];
	assign p2 = press_lo_q[31:16];
	assign p3 = press_lo_q[47:32];
	assign p4 = press_lo_q[63:48];
	assign p5 = press_hi_q[15:0];
	assign p6 = press_hi_q[31:16];
	assign p7 = press_hi_q[47:32];
	assign p8 = press_hi_q[63:48];
	assign p9 = press_last_q;

	// a transaction is taken every cycle start is high
	logic accept;
	assign busy   = 1'b0;
	assign accept = start && !busy;

	// valid bits before and after the divider
	logic [12:1] vld_pre_s;
	logic [19:13] vld_post_s;
	logic         div_vld;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_pre_s  <= '0;
			vld_post_s <= '0;
		end else begin
			vld_pre_s  <= {vld_pre_s[11:1], accept};
			vld_post_s <= {vld_post_s[18:13], div_vld};
		end
	end

	// ---------------- temperature ----------------
	logic [8:1][19:0]    rp_s;
	logic signed [18:0]  x1_s1;
	logic signed [17:0]  d_s1;
	logic signed [34:0]  ta_full;
	logic signed [35:0]  dsq_full;
	logic signed [23:0]  ta_s2, ta_s3;
	logic [31:0]         dd_s2;
	logic signed [36:0]  tb_s3;
	logic signed [31:0]  tfine_s4;
	logic signed [31:0]  t5_full;
	logic [12:5][19:0]   temp_s;
	logic signed [31:0]  pa_s5;

	assign ta_full  = x1_s1 * t2;
	assign dsq_full = d_s1 * d_s1;
	// tfine * 5 + 128 by shift and add
	assign t5_full  = (tfine_s4 <<< 2) + tfine_s4 + 32'sd128;

	always_ff @(posedge clk) begin
		// s1: offsets from the raw reading
		x1_s1 <= $signed({2'b00, sample.raw_temperature[19:3]}) - $signed({2'b00, t1, 1'b0});
		d_s1  <= $signed({2'b00, sample.raw_temperature[19:4]}) - $signed({2'b00, t1});
		rp_s  <= {rp_s[7:1], sample.raw_pressure};
		// s2: linear term and square
		ta_s2 <= ta_full[34:11];
		dd_s2 <= dsq_full[31:0];
		// s3: quadratic term
		tb_s3 <= $signed({1'b0, dd_s2[31:12]}) * t3;
		ta_s3 <= ta_s2;
		// s4: fine temperature
		tfine_s4 <= 32'(ta_s3) + 32'(tb_s3 >>> 14);
		// s5: centi-degrees and pressure offset
		temp_s <= {temp_s[11:5], t5_full[27:8]};
		pa_s5  <= tfine_s4 - TFINE_BASE;
	end

	// ---------------- pressure, divisor and numerator ----------------
	logic signed [47:0] aa_full;
	logic [63:0]        aa_s6;
	logic signed [47:0] ap5_s6, ap2_s6, ap5_s7, ap2_s7;
	logic signed [66:0] aap6_full, aap3_full;
	logic signed [63:0] aap6_s7, aap3_s7;
	logic signed [63:0] aap3_sh;
	logic [63:0]        b_s8, u_s8, nb_s9;
	logic [63:0]        mulu_prod, muln_prod;
	logic [63:0]        den_s11;
	logic [63:0]        un_s12, ud_s12;
	logic               neg_s12, zero_s12;

	// square of the offset stays below 2^45
	assign aa_full   = pa_s5 * pa_s5;
	assign aap6_full = $signed({1'b0, aa_s6[49:0]}) * p6;
	assign aap3_full = $signed({1'b0, aa_s6[49:0]}) * p3;
	// arithmetic shift of the signed quadratic term
	assign aap3_sh   = aap3_s7 >>> 8;

	always_ff @(posedge clk) begin
		// s6: square of the offset and the linear products
		aa_s6  <= 64'(aa_full);
		ap5_s6 <= pa_s5 * p5;
		ap2_s6 <= pa_s5 * p2;
		// s7: quadratic products, wrapping to 64 bits
		aap6_s7 <= aap6_full[63:0];
		aap3_s7 <= aap3_full[63:0];
		ap5_s7  <= ap5_s6;
		ap2_s7  <= ap2_s6;
		// s8: numerator correction and divisor base
		b_s8 <= aap6_s7 + (64'(ap5_s7) << 17) + ({{48{p4[15]}}, p4} << 35);
		u_s8 <= aap3_sh + (64'(ap2_s7) << 12) + P1_OFFSET;
		// s9: numerator before scaling
		nb_s9 <= ({43'd0, RAW_FULL - {1'b0, rp_s[8]}} << 31) - b_s8;
		// s11: divisor
		den_s11 <= 64'($signed(mulu_prod) >>> 33);
		// s12: magnitudes and sign of the quotient
		un_s12   <= muln_prod[63] ? 64'd0 - muln_prod : muln_prod;
		ud_s12   <= den_s11[63] ? 64'd0 - den_s11 : den_s11;
		neg_s12  <= muln_prod[63] ^ den_s11[63];
		zero_s12 <= (den_s11 == 64'd0);
	end

	// divisor scale by P1, launched from s8, result lines up with s10
	ptc_mul64 u_mul_p1 (
		.clk  (clk),
		.x    (u_s8),
		.y    ({48'd0, p1}),
		.prod (mulu_prod)
	);

	// numerator scale, launched from s9, result lines up with s11
	ptc_mul64 u_mul_scale (
		.clk  (clk),
		.x    (nb_s9),
		.y    (PRESS_SCALE),
		.prod (muln_prod)
	);

	// ---------------- division ----------------
	logic [63:0]        quo;
	logic [SIDE_W-1:0]  side_out;

	ptc_div #(
		.W  (DIV_W),
		.SW (SIDE_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (vld_pre_s[12]),
		.num      (un_s12),
		.den      (ud_s12),
		.side_in  ({zero_s12, neg_s12, temp_s[12]}),
		.out_vld  (div_vld),
		.quo      (quo),
		.side_out (side_out)
	);

	// ---------------- pressure, final correction ----------------
	logic [63:0]         p_s13, p_s14, p_s15, p_s16, p_s17;
	logic [18:13]        zero_s;
	logic [18:13][19:0]  tpost_s;
	logic [63:0]         mula_prod, mulb_prod, mulc_prod;
	logic [63:0]         b_s16, b_s17, sum_s18;
	logic [63:0]         fin;
	out_t                result_s19;

	assign fin = 64'($signed(sum_s18) >>> 8) + ({{48{p7[15]}}, p7} << 4);

	always_ff @(posedge clk) begin
		// s13: signed quotient
		p_s13   <= side_out[SIDE_W-2] ? 64'd0 - quo : quo;
		zero_s  <= {zero_s[17:13], side_out[SIDE_W-1]};
		tpost_s <= {tpost_s[17:13], side_out[19:0]};
		p_s14   <= p_s13;
		p_s15   <= p_s14;
		p_s16   <= p_s15;
		p_s17   <= p_s16;
		b_s16   <= 64'($signed(mulb_prod) >>> 19);
		b_s17   <= b_s16;
		// s18: sum of the three terms
		sum_s18 <= p_s17 + 64'($signed(mulc_prod) >>> 25) + b_s17;
		// s19: output register, zero divisor forces zero pressure
		result_s19.temperature_centi <= tpost_s[18];
		result_s19.pressure_fixed    <= zero_s[18] ? 32'd0 : fin[31:0];
	end

	// P9 times the shifted quotient
	ptc_mul64 u_mul_p9 (
		.clk  (clk),
		.x    (64'($signed(p_s13) >>> 13)),
		.y    ({{48{p9[15]}}, p9}),
		.prod (mula_prod)
	);

	// P8 times the quotient
	ptc_mul64 u_mul_p8 (
		.clk  (clk),
		.x    (p_s13),
		.y    ({{48{p8[15]}}, p8}),
		.prod (mulb_prod)
	);

	// second factor of the shifted quotient
	ptc_mul64 u_mul_sq (
		.clk  (clk),
		.x    (mula_prod),
		.y    (64'($signed(p_s15) >>> 13)),
		.prod (mulc_prod)
	);

	assign done   = vld_post_s[19];
	assign result = result_s19;

`ifndef SYNTHESIS
	// every done strobe traces back to a start transaction
	a_done_has_start: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 83))
		else $error("done without a matching start transaction");

	// temperature travels alongside the divider without slipping
	a_temp_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.temperature_centi == $past(temp_s[5], 78))
		else $error("temperature misaligned with its transaction");

	// divider output valid matches its input valid, carried through every divider stage
	a_div_latency: assert property (@(posedge clk) disable iff (!arst_n)
		div_vld |-> $past(vld_pre_s[12], 64))
		else $error("divider valid out of step");
`endif

endmodule

### rtl/ptc_mul64.sv
// ----------------------------------------------------------------------------
// ptc_mul64
// 64 by 64 bit multiply modulo 2^64, two register stages
// ----------------------------------------------------------------------------
module ptc_mul64 (
	input  logic        clk,
	input  logic [63:0] x,
	input  logic [63:0] y,
	output logic [63:0] prod
);
	logic [63:0] ll_s1;
	logic [31:0] lh_s1;
	logic [31:0] hl_s1;
	logic [63:0] prod_s2;

	// partial products, only the low half of the cross terms matters
	always_ff @(posedge clk) begin
		ll_s1   <= 64'(x[31:0]) * 64'(y[31:0]);
		lh_s1   <= x[31:0] * y[63:32];
		hl_s1   <= x[63:32] * y[31:0];
		prod_s2 <= ll_s1 + {lh_s1 + hl_s1, 32'd0};
	end

	assign prod = prod_s2;
endmodule

### rtl/ptc_div.sv
// ----------------------------------------------------------------------------
// ptc_div
// unsigned restoring divider, one quotient bit per pipeline stage
// ----------------------------------------------------------------------------
module ptc_div #(
	parameter int W  = 64,
	parameter int SW = 22
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_vld,
	input  logic [W-1:0]  num,
	input  logic [W-1:0]  den,
	input  logic [SW-1:0] side_in,
	output logic          out_vld,
	output logic [W-1:0]  quo,
	output logic [SW-1:0] side_out
);
	logic [W-1:0]  rem_s  [W];
	logic [W-1:0]  num_s  [W];
	logic [W-1:0]  den_s  [W];
	logic [SW-1:0] side_s [W];
	logic          vld_s  [W];

	for (genvar i = 0; i < W; i++) begin : g_stage
		logic [W-1:0]  rem_in;
		logic [W-1:0]  num_in;
		logic [W-1:0]  den_in;
		logic [SW-1:0] side_w;
		logic          vld_in;
		logic [W:0]    trial;
		logic [W:0]    diff;

		if (i == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = num;
			assign den_in = den;
			assign side_w = side_in;
			assign vld_in = in_vld;
		end else begin : g_next
			assign rem_in = rem_s[i-1];
			assign num_in = num_s[i-1];
			assign den_in = den_s[i-1];
			assign side_w = side_s[i-1];
			assign vld_in = vld_s[i-1];
		end

		assign trial = {rem_in, num_in[W-1]};
		assign diff  = trial - {1'b0, den_in};

		always_ff @(posedge clk) begin
			// borrow out means the divisor does not fit
			if (diff[W]) begin
				rem_s[i] <= trial[W-1:0];
				num_s[i] <= {num_in[W-2:0], 1'b0};
			end else begin
				rem_s[i] <= diff[W-1:0];
				num_s[i] <= {num_in[W-2:0], 1'b1};
			end
			den_s[i]  <= den_in;
			side_s[i] <= side_w;
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[i] <= 1'b0;
			end else begin
				vld_s[i] <= vld_in;
			end
		end
	end

	assign out_vld  = vld_s[W-1];
	assign quo      = num_s[W-1];
	assign side_out = side_s[W-1];
endmodule
